[src/asfpi_pkg.sv]
// shared types, widths and the micro-op schedule of the attitude state-feedback pi core
// no dependencies; compiled first
`default_nettype none

package asfpi_pkg;

    // field and datapath widths
    localparam int SigW     = 16;             // q5.10 signals, moments, thrust
    localparam int ErrW     = SigW + 1;       // exact difference of two q5.10 values
    localparam int IntW     = 24;             // q13.10 integrators
    localparam int LimW     = 23;             // unsigned windup limits
    localparam int PerW     = 16;             // unsigned q0.16 sample period
    localparam int GainW    = 16;             // signed q7.8 gains
    localparam int GainRowW = 4 * GainW;      // packed roll and pitch gain rows
    localparam int GainYawW = 3 * GainW;      // packed yaw gain row
    localparam int OpAW     = IntW + 1;       // multiplier operand a
    localparam int OpBW     = GainW + 1;      // multiplier operand b
    localparam int ProdW    = OpAW + OpBW;    // full product
    localparam int AccW     = ProdW;          // dot-product accumulator
    localparam int SumW     = IntW + 2;       // integrator update before clamping
    localparam int IncLsb   = 16;             // q.26 to q.10 rounding position
    localparam int IncMsb   = 33;             // error times period stays below 2^33
    localparam int MomShift = 8;              // q.18 to q.10 rounding position
    localparam int CfgAW    = 3;
    localparam int CfgDW    = GainRowW;
    localparam int StepW    = 4;

    localparam logic [StepW-1:0] STEP_LAST = 4'd15;

    // register reset values
    localparam logic [PerW-1:0] PeriodRst = 16'd655;
    localparam logic [LimW-1:0] LimRst    = '1;

    // configuration register indexes
    typedef enum logic [CfgAW-1:0] {
        CFG_SAMPLE_PERIOD,
        CFG_WINDUP_ROLL,
        CFG_WINDUP_PITCH,
        CFG_WINDUP_YAW,
        CFG_GAIN_ROLL,
        CFG_GAIN_PITCH,
        CFG_GAIN_YAW
    } t_cfg_idx;

    typedef struct packed {
        logic [PerW-1:0]     sample_period;
        logic [LimW-1:0]     windup_roll;
        logic [LimW-1:0]     windup_pitch;
        logic [LimW-1:0]     windup_yaw;
        logic [GainRowW-1:0] gain_roll;
        logic [GainRowW-1:0] gain_pitch;
        logic [GainYawW-1:0] gain_yaw;
    } t_cfg;

    // one input transaction
    typedef struct packed {
        logic signed [SigW-1:0] roll_angle;
        logic signed [SigW-1:0] roll_rate;
        logic signed [SigW-1:0] roll_accel;
        logic signed [SigW-1:0] pitch_angle;
        logic signed [SigW-1:0] pitch_rate;
        logic signed [SigW-1:0] pitch_accel;
        logic signed [SigW-1:0] yaw_omega;
        logic signed [SigW-1:0] yaw_accel;
        logic signed [SigW-1:0] roll_ref;
        logic signed [SigW-1:0] pitch_ref;
        logic signed [SigW-1:0] yaw_omega_ref;
        logic signed [SigW-1:0] thrust_ref;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic signed [SigW-1:0] moment_x;
        logic signed [SigW-1:0] moment_y;
        logic signed [SigW-1:0] moment_z;
        logic signed [SigW-1:0] thrust_out;
        logic signed [IntW-1:0] integ_roll_out;
        logic signed [IntW-1:0] integ_pitch_out;
        logic signed [IntW-1:0] integ_yaw_out;
    } t_out_item;

    // captured sample with the errors already formed
    typedef struct packed {
        logic signed [ErrW-1:0] err_roll;
        logic signed [ErrW-1:0] err_pitch;
        logic signed [ErrW-1:0] err_yaw;
        logic signed [SigW-1:0] roll_rate;
        logic signed [SigW-1:0] roll_accel;
        logic signed [SigW-1:0] pitch_rate;
        logic signed [SigW-1:0] pitch_accel;
        logic signed [SigW-1:0] yaw_accel;
        logic signed [SigW-1:0] thrust;
    } t_sample;

    // multiplier operand a
    typedef enum logic [3:0] {
        SA_ERR_ROLL,
        SA_ERR_PITCH,
        SA_ERR_YAW,
        SA_INT_ROLL,
        SA_INT_PITCH,
        SA_INT_YAW,
        SA_ROLL_RATE,
        SA_ROLL_ACCEL,
        SA_PITCH_RATE,
        SA_PITCH_ACCEL,
        SA_YAW_ACCEL
    } t_sel_a;

    // multiplier operand b
    typedef enum logic [1:0] {
        SB_PERIOD,
        SB_GAIN_ROLL,
        SB_GAIN_PITCH,
        SB_GAIN_YAW
    } t_sel_b;

    // accumulator action on the previous cycle's product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    // post-processing on the registered product or accumulator
    typedef enum logic [2:0] {
        POST_NONE,
        POST_INT_ROLL,
        POST_INT_PITCH,
        POST_INT_YAW,
        POST_MOM_ROLL,
        POST_MOM_PITCH
    } t_post;

    typedef struct packed {
        t_sel_a     sel_a;
        t_sel_b     sel_b;
        logic [1:0] gcol;
        t_acc_op    acc_op;
        t_post      post;
    } t_uop;

    typedef struct packed {
        logic en;
        t_uop uop;
    } t_seq_ctl;

    // micro-op schedule: the multiply issued in a step is consumed one step later
    function automatic t_uop uop_at(input logic [StepW-1:0] step);
        t_uop u;
        u = '{sel_a: SA_ERR_ROLL, sel_b: SB_PERIOD, gcol: 2'd0,
              acc_op: ACC_HOLD, post: POST_NONE};
        unique case (step)
            4'd0:  begin u.sel_a = SA_ERR_ROLL;  u.sel_b = SB_PERIOD; end
            4'd1:  begin u.sel_a = SA_ERR_PITCH; u.sel_b = SB_PERIOD; u.post = POST_INT_ROLL; end
            4'd2:  begin u.sel_a = SA_ERR_YAW;   u.sel_b = SB_PERIOD; u.post = POST_INT_PITCH; end
            4'd3:  begin
                u.sel_a = SA_INT_ROLL; u.sel_b = SB_GAIN_ROLL; u.gcol = 2'd0;
                u.post  = POST_INT_YAW;
            end
            4'd4:  begin
                u.sel_a = SA_ERR_ROLL; u.sel_b = SB_GAIN_ROLL; u.gcol = 2'd1;
                u.acc_op = ACC_LOAD;
            end
            4'd5:  begin
                u.sel_a = SA_ROLL_RATE; u.sel_b = SB_GAIN_ROLL; u.gcol = 2'd2;
                u.acc_op = ACC_ADD;
            end
            4'd6:  begin
                u.sel_a = SA_ROLL_ACCEL; u.sel_b = SB_GAIN_ROLL; u.gcol = 2'd3;
                u.acc_op = ACC_ADD;
            end
            4'd7:  begin
                u.sel_a = SA_INT_PITCH; u.sel_b = SB_GAIN_PITCH; u.gcol = 2'd0;
                u.acc_op = ACC_ADD;
            end
            4'd8:  begin
                u.sel_a = SA_ERR_PITCH; u.sel_b = SB_GAIN_PITCH; u.gcol = 2'd1;
                u.acc_op = ACC_LOAD; u.post = POST_MOM_ROLL;
            end
            4'd9:  begin
                u.sel_a = SA_PITCH_RATE; u.sel_b = SB_GAIN_PITCH; u.gcol = 2'd2;
                u.acc_op = ACC_ADD;
            end
            4'd10: begin
                u.sel_a = SA_PITCH_ACCEL; u.sel_b = SB_GAIN_PITCH; u.gcol = 2'd3;
                u.acc_op = ACC_ADD;
            end
            4'd11: begin
                u.sel_a = SA_INT_YAW; u.sel_b = SB_GAIN_YAW; u.gcol = 2'd0;
                u.acc_op = ACC_ADD;
            end
            4'd12: begin
                u.sel_a = SA_ERR_YAW; u.sel_b = SB_GAIN_YAW; u.gcol = 2'd1;
                u.acc_op = ACC_LOAD; u.post = POST_MOM_PITCH;
            end
            4'd13: begin
                u.sel_a = SA_YAW_ACCEL; u.sel_b = SB_GAIN_YAW; u.gcol = 2'd2;
                u.acc_op = ACC_ADD;
            end
            4'd14: begin u.acc_op = ACC_ADD; end
            default: begin end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[src/asfpi_in_if.sv]
// sample channel: valid/ready handshake carrying one measurement and reference set
// depends on asfpi_pkg
`default_nettype none

interface asfpi_in_if;
    import asfpi_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/asfpi_out_if.sv]
// result channel: valid/ready handshake carrying moments, thrust and integrators
// depends on asfpi_pkg
`default_nettype none

interface asfpi_out_if;
    import asfpi_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/asfpi_seq.sv]
// step sequencer driving the shared multiply-accumulate unit through the schedule
// depends on asfpi_pkg (uop_at, t_seq_ctl)
`default_nettype none

module asfpi_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_out_free,
    output asfpi_pkg::t_seq_ctl     o_ctl,
    output logic                    o_ready,
    output logic                    o_done
);
    import asfpi_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state           r_state, n_state;
    logic [StepW-1:0] r_step,  n_step;

    // last step completes only when the result register can take the transaction
    assign o_done  = (r_state == ST_RUN) && (r_step == STEP_LAST) && i_out_free;
    assign o_ready = (r_state == ST_IDLE) || o_done;

    assign o_ctl.en  = (r_state == ST_RUN);
    assign o_ctl.uop = uop_at(r_step);

    // next state and step
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (r_step != STEP_LAST) begin
                    n_step = r_step + 1'b1;
                end else if (i_out_free) begin
                    if (i_start) begin
                        n_step = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // a running item walks the schedule one step per cycle until the final step, which can stall
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != STEP_LAST)
            |=> (r_state == ST_RUN && r_step == $past(r_step) + 1'b1))
        else $error("sequencer skipped or held a step");

    // the final step holds while the result register cannot take the transaction
    a_idle_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && $past(r_state) == ST_RUN && r_step == STEP_LAST && !i_out_free)
            |=> (r_state == ST_RUN && r_step == STEP_LAST))
        else $error("final step left while result register was full");

endmodule

`default_nettype wire

[src/asfpi_unit.sv]
// shared multiply-accumulate unit with integrator update and moment rounding
// depends on asfpi_pkg (types, widths)
`default_nettype none

module asfpi_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire asfpi_pkg::t_seq_ctl               i_ctl,
    input  wire asfpi_pkg::t_cfg                   i_cfg,
    input  wire asfpi_pkg::t_sample                i_smp,
    output logic signed [asfpi_pkg::SigW-1:0]      o_moment_x,
    output logic signed [asfpi_pkg::SigW-1:0]      o_moment_y,
    output logic signed [asfpi_pkg::SigW-1:0]      o_moment_z,
    output logic signed [asfpi_pkg::IntW-1:0]      o_integ_roll,
    output logic signed [asfpi_pkg::IntW-1:0]      o_integ_pitch,
    output logic signed [asfpi_pkg::IntW-1:0]      o_integ_yaw
);
    import asfpi_pkg::*;

    localparam logic signed [AccW:0]          RndBias = 128;
    localparam logic signed [AccW-MomShift:0] MomMax  = 32767;
    localparam logic signed [AccW-MomShift:0] MomMin  = -32768;

    // round error times period to q.10, add, clamp symmetrically
    function automatic logic signed [IntW-1:0] integrate(
        input logic signed [IntW-1:0]  acc,
        input logic signed [ProdW-1:0] p,
        input logic [LimW-1:0]         lim
    );
        logic signed [SumW-1:0] inc;
        logic signed [SumW-1:0] sum;
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        inc = SumW'(signed'(p[IncMsb:IncLsb]));
        sum = SumW'(acc) + inc + SumW'(signed'({1'b0, p[IncLsb-1]}));
        hi  = SumW'(signed'({1'b0, lim}));
        lo  = -hi;
        if (sum > hi) begin
            sum = hi;
        end else if (sum < lo) begin
            sum = lo;
        end
        return IntW'(sum);
    endfunction

    // negate, round half up to q.10 and saturate to the signal range
    function automatic logic signed [SigW-1:0] sat_moment(input logic signed [AccW-1:0] s);
        logic signed [AccW:0]          t;
        logic signed [AccW-MomShift:0] v;
        t = RndBias - (AccW+1)'(s);
        v = t[AccW:MomShift];
        if (v > MomMax) begin
            v = MomMax;
        end else if (v < MomMin) begin
            v = MomMin;
        end
        return SigW'(v);
    endfunction

    logic signed [OpAW-1:0]   op_a;
    logic signed [OpBW-1:0]   op_b;
    logic [GainRowW-1:0]      gain_row;
    logic signed [GainW-1:0]  gain;
    logic signed [ProdW-1:0]  prod;

    logic signed [ProdW-1:0]  r_prod;
    logic signed [AccW-1:0]   r_acc;
    logic signed [IntW-1:0]   r_integ_roll;
    logic signed [IntW-1:0]   r_integ_pitch;
    logic signed [IntW-1:0]   r_integ_yaw;
    logic signed [SigW-1:0]   r_mom_x;
    logic signed [SigW-1:0]   r_mom_y;

    // operand a selection
    always_comb begin
        unique case (i_ctl.uop.sel_a)
            SA_ERR_ROLL:    op_a = OpAW'(i_smp.err_roll);
            SA_ERR_PITCH:   op_a = OpAW'(i_smp.err_pitch);
            SA_ERR_YAW:     op_a = OpAW'(i_smp.err_yaw);
            SA_INT_ROLL:    op_a = OpAW'(r_integ_roll);
            SA_INT_PITCH:   op_a = OpAW'(r_integ_pitch);
            SA_INT_YAW:     op_a = OpAW'(r_integ_yaw);
            SA_ROLL_RATE:   op_a = OpAW'(i_smp.roll_rate);
            SA_ROLL_ACCEL:  op_a = OpAW'(i_smp.roll_accel);
            SA_PITCH_RATE:  op_a = OpAW'(i_smp.pitch_rate);
            SA_PITCH_ACCEL: op_a = OpAW'(i_smp.pitch_accel);
            SA_YAW_ACCEL:   op_a = OpAW'(i_smp.yaw_accel);
            default:        op_a = '0;
        endcase
    end

    // operand b selection: period or one gain of a row
    always_comb begin
        unique case (i_ctl.uop.sel_b)
            SB_GAIN_PITCH: gain_row = i_cfg.gain_pitch;
            SB_GAIN_YAW:   gain_row = {{(GainRowW-GainYawW){1'b0}}, i_cfg.gain_yaw};
            default:       gain_row = i_cfg.gain_roll;
        endcase
        gain = signed'(gain_row[GainW*i_ctl.uop.gcol +: GainW]);
        if (i_ctl.uop.sel_b == SB_PERIOD) begin
            op_b = signed'({1'b0, i_cfg.sample_period});
        end else begin
            op_b = OpBW'(gain);
        end
    end

    assign prod = ProdW'(op_a) * ProdW'(op_b);

    // product register, accumulator and moment holding registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= prod;
            unique case (i_ctl.uop.acc_op)
                ACC_LOAD: r_acc <= r_prod;
                ACC_ADD:  r_acc <= r_acc + r_prod;
                default:  r_acc <= r_acc;
            endcase
            if (i_ctl.uop.post == POST_MOM_ROLL) begin
                r_mom_x <= sat_moment(r_acc);
            end
            if (i_ctl.uop.post == POST_MOM_PITCH) begin
                r_mom_y <= sat_moment(r_acc);
            end
        end
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_roll  <= '0;
            r_integ_pitch <= '0;
            r_integ_yaw   <= '0;
        end else if (i_ctl.en) begin
            unique case (i_ctl.uop.post)
                POST_INT_ROLL:
                    r_integ_roll <= integrate(r_integ_roll, r_prod, i_cfg.windup_roll);
                POST_INT_PITCH:
                    r_integ_pitch <= integrate(r_integ_pitch, r_prod, i_cfg.windup_pitch);
                POST_INT_YAW:
                    r_integ_yaw <= integrate(r_integ_yaw, r_prod, i_cfg.windup_yaw);
                default: begin end
            endcase
        end
    end

    assign o_moment_x    = r_mom_x;
    assign o_moment_y    = r_mom_y;
    assign o_moment_z    = sat_moment(r_acc);
    assign o_integ_roll  = r_integ_roll;
    assign o_integ_pitch = r_integ_pitch;
    assign o_integ_yaw   = r_integ_yaw;

    // roll integrator lands inside its windup band after each update
    a_roll_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && i_ctl.uop.post == POST_INT_ROLL)
            |=> (r_integ_roll <= $signed({1'b0, $past(i_cfg.windup_roll)})
                 && r_integ_roll >= -$signed({1'b0, $past(i_cfg.windup_roll)})))
        else $error("roll integrator outside windup limit");

endmodule

`default_nettype wire

[src/attitude_state_feedback_pi_core.sv]
// top level of the attitude state-feedback pi core: config registers, sample capture,
// result register; depends on asfpi_pkg, asfpi_in_if, asfpi_out_if, asfpi_seq, asfpi_unit
`default_nettype none

// channel   | direction | handshake        | payload
// i_smp     | in        | valid / ready    | t_in_item, twelve q5.10 fields
// o_res     | out       | valid / ready    | t_out_item, moments, thrust, integrators
// i_cfg_*   | in        | write enable     | register index, 64-bit write data
//
// for each sample the shared multiplier issues 14 operations in a fixed
// schedule (three integrator steps, eleven gain products), the accumulator takes the
// last product one step later and the final step rounds the yaw moment into the
// result register
// a new sample is taken in the cycle its predecessor's result is registered
// reset is synchronous and active low; integrators clear, config registers take their defaults
// the final step stalls while the result register still holds an untaken transaction

module attitude_state_feedback_pi_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [asfpi_pkg::CfgAW-1:0]    i_cfg_idx,
    input  wire logic [asfpi_pkg::CfgDW-1:0]    i_cfg_data,
    asfpi_in_if.sink                            i_smp,
    asfpi_out_if.source                         o_res
);
    import asfpi_pkg::*;

    t_cfg      r_cfg, n_cfg;
    t_sample   r_smp;
    t_out_item r_out;
    logic      r_out_valid;

    t_seq_ctl  ctl;
    logic      seq_ready;
    logic      done;
    logic      accept;

    logic signed [SigW-1:0] mom_x, mom_y, mom_z;
    logic signed [IntW-1:0] integ_roll, integ_pitch, integ_yaw;

    assign accept      = i_smp.valid && seq_ready;
    assign i_smp.ready = seq_ready;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_PERIOD: n_cfg.sample_period = i_cfg_data[PerW-1:0];
                CFG_WINDUP_ROLL:   n_cfg.windup_roll   = i_cfg_data[LimW-1:0];
                CFG_WINDUP_PITCH:  n_cfg.windup_pitch  = i_cfg_data[LimW-1:0];
                CFG_WINDUP_YAW:    n_cfg.windup_yaw    = i_cfg_data[LimW-1:0];
                CFG_GAIN_ROLL:     n_cfg.gain_roll     = i_cfg_data[GainRowW-1:0];
                CFG_GAIN_PITCH:    n_cfg.gain_pitch    = i_cfg_data[GainRowW-1:0];
                CFG_GAIN_YAW:      n_cfg.gain_yaw      = i_cfg_data[GainYawW-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period <= PeriodRst;
            r_cfg.windup_roll   <= LimRst;
            r_cfg.windup_pitch  <= LimRst;
            r_cfg.windup_yaw    <= LimRst;
            r_cfg.gain_roll     <= '0;
            r_cfg.gain_pitch    <= '0;
            r_cfg.gain_yaw      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sample capture with the three control errors formed on the way in
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp.err_roll    <= ErrW'(i_smp.data.roll_angle) - ErrW'(i_smp.data.roll_ref);
            r_smp.err_pitch   <= ErrW'(i_smp.data.pitch_angle) - ErrW'(i_smp.data.pitch_ref);
            r_smp.err_yaw     <= ErrW'(i_smp.data.yaw_omega) - ErrW'(i_smp.data.yaw_omega_ref);
            r_smp.roll_rate   <= i_smp.data.roll_rate;
            r_smp.roll_accel  <= i_smp.data.roll_accel;
            r_smp.pitch_rate  <= i_smp.data.pitch_rate;
            r_smp.pitch_accel <= i_smp.data.pitch_accel;
            r_smp.yaw_accel   <= i_smp.data.yaw_accel;
            r_smp.thrust      <= i_smp.data.thrust_ref;
        end
    end

    asfpi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (!r_out_valid || o_res.ready),
        .o_ctl      (ctl),
        .o_ready    (seq_ready),
        .o_done     (done)
    );

    asfpi_unit u_unit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_cfg         (r_cfg),
        .i_smp         (r_smp),
        .o_moment_x    (mom_x),
        .o_moment_y    (mom_y),
        .o_moment_z    (mom_z),
        .o_integ_roll  (integ_roll),
        .o_integ_pitch (integ_pitch),
        .o_integ_yaw   (integ_yaw)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.moment_x        <= mom_x;
            r_out.moment_y        <= mom_y;
            r_out.moment_z        <= mom_z;
            r_out.thrust_out      <= r_smp.thrust;
            r_out.integ_roll_out  <= integ_roll;
            r_out.integ_pitch_out <= integ_pitch;
            r_out.integ_yaw_out   <= integ_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // an accepted sample blocks the input until its schedule has run
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_smp.ready)
        else $error("input ready straight after a sample transaction");

endmodule

`default_nettype wire
